[rtl/core/hcbp_pkg.sv]
package hcbp_pkg;

  localparam int CODE_W   = 32;               // code word width
  localparam int LEN_W    = 6;                // code length field width
  localparam int BYTE_W   = 8;
  localparam int PEND_W   = 7;                // bits that can wait for a byte
  localparam int CNT_W    = 3;                // 0..7 waiting bits
  localparam int SYM_W    = 8;
  localparam int ACC_W    = PEND_W + CODE_W;  // pending bits plus one code
  localparam int STREAM_W = ACC_W + 1;        // whole bytes, left aligned
  localparam int NB_W     = 3;                // up to four bytes per code
  localparam int ENTRY_W  = CODE_W + LEN_W;   // table entry {code, len}

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_ENCODE = 2'd1,
    CMD_FLUSH  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EMIT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic ram_we;      // write table entry
    logic ram_re;      // look up table entry
    logic pack;        // merge looked-up code with pending bits
    logic flush_load;  // pad pending bits into one byte
    logic shift;       // current byte transferred, move to next
  } dp_ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic in_range;    // symbol indexes the table
    logic pend_nz;     // pending bits waiting
    logic has_bytes;   // pack yields at least one byte
    logic last_byte;   // byte on the output is the final one
  } dp_stat_t;

endpackage

[rtl/core/hcbp_ram.sv]
module hcbp_ram #(
  parameter int WIDTH = 38,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/hcbp_ctrl.sv]
module hcbp_ctrl import hcbp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] cmd,
  output logic       out_valid,
  input  logic       out_stall,
  input  dp_stat_t   stat,
  output dp_ctrl_t   ctl
);

  state_t state, state_next;
  logic   accept;

  assign accept    = in_valid && (state == ST_IDLE);
  assign in_stall  = (state != ST_IDLE);
  assign out_valid = (state == ST_EMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (cmd_t'(cmd))
            CMD_ENCODE: if (stat.in_range) state_next = ST_READ;
            CMD_FLUSH:  if (stat.pend_nz) state_next = ST_EMIT;
            default:    state_next = ST_IDLE;
          endcase
        end
      end
      ST_READ: begin
        state_next = stat.has_bytes ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (!out_stall && stat.last_byte) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    ctl = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (cmd_t'(cmd))
            CMD_LOAD:   ctl.ram_we     = stat.in_range;
            CMD_ENCODE: ctl.ram_re     = stat.in_range;
            CMD_FLUSH:  ctl.flush_load = stat.pend_nz;
            default:    ctl = '0;
          endcase
        end
      end
      ST_READ: ctl.pack  = 1'b1;
      ST_EMIT: ctl.shift = !out_stall;
      default: ctl = '0;
    endcase
  end

endmodule

[rtl/core/hcbp_dp.sv]
module hcbp_dp import hcbp_pkg::*; #(
  parameter int NUM_SYMBOLS  = 256,
  parameter int MAX_CODE_LEN = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [SYM_W-1:0]  symbol,
  input  logic [CODE_W-1:0] code_bits,
  input  logic [LEN_W-1:0]  code_len,
  input  dp_ctrl_t          ctl,
  output dp_stat_t          stat,
  output logic [BYTE_W-1:0] out_byte,
  output logic              last
);

  localparam int AW      = $clog2(NUM_SYMBOLS);
  localparam int LEN_CAP = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

  logic [PEND_W-1:0]   pend_bits;
  logic [CNT_W-1:0]    pend_cnt;
  logic [NB_W-1:0]     bytes_left;
  logic [STREAM_W-1:0] stream;

  logic [LEN_W-1:0]    len_capped;
  logic [ENTRY_W-1:0]  rd_entry;
  logic [CODE_W-1:0]   rd_code;
  logic [LEN_W-1:0]    rd_len;
  logic [ACC_W-1:0]    code_mask;
  logic [ACC_W-1:0]    acc;
  logic [LEN_W-1:0]    total;
  logic [STREAM_W-1:0] aligned;
  logic [PEND_W-1:0]   rem_mask;
  logic [3:0]          flush_sh;
  logic [BYTE_W-1:0]   flush_byte;

  assign len_capped = (code_len > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP) : code_len;

  hcbp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_SYMBOLS)
  ) u_table (
    .clk   (clk),
    .we    (ctl.ram_we),
    .waddr (symbol[AW-1:0]),
    .wdata ({code_bits, len_capped}),
    .re    (ctl.ram_re),
    .raddr (symbol[AW-1:0]),
    .rdata (rd_entry)
  );

  assign rd_code = rd_entry[ENTRY_W-1:LEN_W];
  assign rd_len  = rd_entry[LEN_W-1:0];

  // pending bits followed by the code, right aligned, then left aligned
  always_comb begin
    code_mask = (ACC_W'(1) << rd_len) - ACC_W'(1);
    acc       = (ACC_W'(pend_bits) << rd_len) | (ACC_W'(rd_code) & code_mask);
    total     = LEN_W'(pend_cnt) + rd_len;
    aligned   = {1'b0, acc} << (LEN_W'(STREAM_W) - total);
    rem_mask  = (PEND_W'(1) << total[CNT_W-1:0]) - PEND_W'(1);
    flush_sh   = 4'(BYTE_W) - {1'b0, pend_cnt};
    flush_byte = {1'b0, pend_bits} << flush_sh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_bits  <= '0;
      pend_cnt   <= '0;
      bytes_left <= '0;
    end else begin
      if (ctl.pack) begin
        pend_bits  <= acc[PEND_W-1:0] & rem_mask;
        pend_cnt   <= total[CNT_W-1:0];
        bytes_left <= total[LEN_W-1:CNT_W];
      end else if (ctl.flush_load) begin
        pend_bits  <= '0;
        pend_cnt   <= '0;
        bytes_left <= NB_W'(1);
      end else if (ctl.shift) begin
        bytes_left <= bytes_left - NB_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.pack) begin
      stream <= aligned;
    end else if (ctl.flush_load) begin
      stream <= {flush_byte, (STREAM_W - BYTE_W)'(0)};
    end else if (ctl.shift) begin
      stream <= {stream[STREAM_W-BYTE_W-1:0], BYTE_W'(0)};
    end
  end

  assign out_byte = stream[STREAM_W-1 -: BYTE_W];
  assign last     = (bytes_left == NB_W'(1));

  assign stat.in_range  = ({1'b0, symbol} < (SYM_W + 1)'(NUM_SYMBOLS));
  assign stat.pend_nz   = (pend_cnt != '0);
  assign stat.has_bytes = (total[LEN_W-1:CNT_W] != '0);
  assign stat.last_byte = last;

  // no stale bits above the pending count
  a_pend_clean: assert property (@(posedge clk) disable iff (rst)
    (({1'b0, pend_bits} >> pend_cnt) == '0))
    else $error("pending bits above count");

  // a byte is moved only while one is left
  a_shift_nonempty: assert property (@(posedge clk) disable iff (rst)
    ctl.shift |-> (bytes_left != '0))
    else $error("byte shift with nothing left");

  // flush leaves exactly one byte and an empty buffer
  a_flush_state: assert property (@(posedge clk) disable iff (rst)
    ctl.flush_load |=> (pend_cnt == '0) && (bytes_left == NB_W'(1)))
    else $error("flush did not clear buffer");

  // one code never yields more than four bytes
  a_bytes_max: assert property (@(posedge clk) disable iff (rst)
    (bytes_left <= NB_W'(4)))
    else $error("byte count out of range");

endmodule

[rtl/core/huffman_code_bit_packer_unit.sv]
// Table-driven Huffman bit packer. A load command (cmd 0) writes the code
// word and length for one symbol into a NUM_SYMBOLS-entry table; lengths
// above MAX_CODE_LEN (or 32) are clipped on the way in. An encode command
// (cmd 1) looks the symbol up and appends its code, MSB first, to the
// partial byte; every byte that fills up is sent out MSB first, and last
// marks the final byte an encode produced. A flush command (cmd 2) pads the
// partial byte with zeros, sends it with last set and empties the buffer.
// Loads and empty flushes send nothing, nor do unused commands or symbols
// past the table. Encoding a symbol that was never loaded gives undefined
// bytes. A load or a no-op is done when it is accepted; a non-empty flush
// also makes one output transfer; an encode looks the symbol up through the
// registered RAM read, then packs it, then sends each output byte (0 to 4)
// in its own transfer, because the single output register moves one byte per transfer.
// The input is stalled until all bytes of the current item are taken.
module huffman_code_bit_packer_unit import hcbp_pkg::*; #(
  parameter int NUM_SYMBOLS  = 256,
  parameter int MAX_CODE_LEN = 32
) (
  input  logic              clk,
  input  logic              rst,
  // input channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        cmd,
  input  logic [SYM_W-1:0]  symbol,
  input  logic [CODE_W-1:0] code_bits,
  input  logic [LEN_W-1:0]  code_len,
  // output channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic [BYTE_W-1:0] out_byte,
  output logic              last
);

  dp_ctrl_t ctl;   // commands into the datapath
  dp_stat_t stat;  // datapath status for sequencing

  // sequencer: idle / table read / byte emit
  hcbp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .ctl       (ctl)
  );

  // code table, pending-bit buffer and byte shifter
  hcbp_dp #(
    .NUM_SYMBOLS  (NUM_SYMBOLS),
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .symbol    (symbol),
    .code_bits (code_bits),
    .code_len  (code_len),
    .ctl       (ctl),
    .stat      (stat),
    .out_byte  (out_byte),
    .last      (last)
  );

endmodule

[dv/tb_huffman_code_bit_packer_unit.sv]
`timescale 1ns / 100ps

module tb_huffman_code_bit_packer_unit;
  import hcbp_pkg::*;

  localparam int NUM_SYMBOLS  = 256;
  localparam int MAX_CODE_LEN = 32;
  // stored lengths clip to the smaller of the parameter and the code width
  localparam int LEN_CAP      = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int HOLD_CYCLES  = 400;      // long receiver hold-off
  localparam int CYCLE_LIMIT  = 200000;   // generous run limit
  localparam int DRAIN_CYCLES = 10;       // extra cycles after the last byte

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        cmd = '0;
  logic [SYM_W-1:0]  symbol = '0;
  logic [CODE_W-1:0] code_bits = '0;
  logic [LEN_W-1:0]  code_len = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [BYTE_W-1:0] out_byte;
  logic              last;

  huffman_code_bit_packer_unit #(
    .NUM_SYMBOLS  (NUM_SYMBOLS),
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .symbol    (symbol),
    .code_bits (code_bits),
    .code_len  (code_len),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .last      (last)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------
  // Packer state mirror: code table, clipped lengths, partial byte.
  // ---------------------------------------------------------------------
  logic [CODE_W-1:0] code_mem [NUM_SYMBOLS];
  logic [LEN_W-1:0]  len_mem  [NUM_SYMBOLS];
  bit                loaded   [NUM_SYMBOLS];
  logic [7:0]        loaded_syms [$];   // symbols safe to encode
  logic [PEND_W-1:0] pend_bits = '0;
  logic [CNT_W-1:0]  pend_cnt  = '0;

  typedef struct packed {
    logic [7:0] b;
    logic       last;
  } byte_due_t;

  byte_due_t bytes_due [$];   // packed bytes not yet seen on the output

  int mismatches    = 0;
  int bytes_checked = 0;
  int items_sent    = 0;
  int cycles        = 0;
  int tx_idle_pct   = 0;      // only the stimulus process uses this
  int rx_stall_pct  = 0;
  int hold_reqs     = 0;

  // Applies one input transfer to the mirror; returns the number of bytes
  // it yields, byte k in bits [31-8k -: 8].
  function automatic int pack_input(input logic [1:0] c, input logic [7:0] s,
                                    input logic [31:0] w, input logic [5:0] l,
                                    output logic [31:0] bytes_out);
    logic [7:0] acc;
    int         cnt;
    int         n;
    int         len;
    bytes_out = '0;
    n = 0;
    case (c)
      CMD_LOAD: begin
        code_mem[s] = w;
        len_mem[s]  = (int'(l) > LEN_CAP) ? LEN_W'(LEN_CAP) : l;
        if (!loaded[s]) begin
          loaded[s] = 1'b1;
          loaded_syms.push_back(s);
        end
      end
      CMD_ENCODE: begin
        acc = {1'b0, pend_bits};
        cnt = int'(pend_cnt);
        len = int'(len_mem[s]);
        // MSB of the code goes in first
        for (int i = len - 1; i >= 0; i--) begin
          acc = {acc[6:0], code_mem[s][i]};
          cnt++;
          if (cnt == BYTE_W) begin
            bytes_out[31 - 8 * n -: 8] = acc;
            n++;
            acc = '0;
            cnt = 0;
          end
        end
        pend_bits = acc[PEND_W-1:0];
        pend_cnt  = cnt[CNT_W-1:0];
      end
      CMD_FLUSH: begin
        if (pend_cnt != 0) begin
          // pad on the right with zeros
          acc = {1'b0, pend_bits} << (BYTE_W - int'(pend_cnt));
          bytes_out[31:24] = acc;
          n = 1;
          pend_bits = '0;
          pend_cnt  = '0;
        end
      end
      default: ;   // unused command, no effect
    endcase
    return n;
  endfunction

  task automatic flag_mismatch(input string what);
    $display("ERROR @%0t: %s", $time, what);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------
  // Input side. Offers one item, waits for its transfer, then records the
  // bytes it must produce (typed-in bytes where given, else the mirror's).
  // ---------------------------------------------------------------------
  task automatic send_item(input logic [1:0] c, input logic [7:0] s, input logic [31:0] w,
                           input logic [5:0] l, input logic typed, input int n_typed,
                           input logic [31:0] typed_bytes);
    logic [31:0] got;
    int          n;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    cmd       <= c;
    symbol    <= s;
    code_bits <= w;
    code_len  <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n = pack_input(c, s, w, l, got);
    if (typed) begin
      n   = n_typed;
      got = typed_bytes;
    end
    for (int k = 0; k < n; k++)
      bytes_due.push_back('{got[31 - 8 * k -: 8], k == n - 1});
    items_sent++;
  endtask

  // Mostly encodes of loaded symbols with junk in the unused fields; loads
  // spread over the length range, flushes and the odd unused command.
  task automatic send_random_item();
    int          pick;
    int          lsel;
    logic [7:0]  s;
    logic [31:0] w;
    logic [5:0]  l;
    pick = $urandom_range(0, 99);
    lsel = $urandom_range(0, 99);
    s = 8'($urandom_range(0, 255));
    w = $urandom();
    l = 6'($urandom_range(0, 63));
    if (pick < 15 || loaded_syms.size() == 0) begin
      case ($urandom_range(0, 9))
        0: w = '1;
        1: w = '0;
        default: ;
      endcase
      if (lsel < 5)       l = '0;
      else if (lsel < 10) l = 6'($urandom_range(LEN_CAP + 1, 63));   // clipped
      else if (lsel < 30) l = 6'($urandom_range(1, 8));
      else                l = 6'($urandom_range(1, LEN_CAP));
      send_item(CMD_LOAD, s, w, l, 1'b0, 0, '0);
    end else if (pick < 84) begin
      s = loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
      send_item(CMD_ENCODE, s, w, l, 1'b0, 0, '0);
    end else if (pick < 96) begin
      send_item(CMD_FLUSH, s, w, l, 1'b0, 0, '0);
    end else begin
      send_item(CMD_UNUSED, s, w, l, 1'b0, 0, '0);
    end
  endtask

  // Sender goes quiet until every byte owed has been transferred.
  task automatic wait_all_bytes();
    in_valid <= 1'b0;
    do @(posedge clk); while (bytes_due.size() != 0);
  endtask

  // ---------------------------------------------------------------------
  // Directed rows. Bytes are typed in where obvious; typed=0 rows go to
  // the mirror. The last typed byte of a row carries last.
  // ---------------------------------------------------------------------
  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  sym;
    logic [31:0] word;
    logic [5:0]  len;
    logic        typed;
    logic [2:0]  n_bytes;
    logic [31:0] bytes;
  } stim_row_t;

  localparam int N_DIRECTED = 24;

  stim_row_t directed_rows [N_DIRECTED] = '{
    // flush right after reset: nothing pending, nothing out
    '{CMD_FLUSH,  8'h00, 32'h0000_0000, 6'd0,  1'b1, 3'd0, 32'h0000_0000},
    // unused command with every field bit set: ignored
    '{CMD_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'h3F, 1'b1, 3'd0, 32'h0000_0000},
    '{CMD_LOAD,   8'h00, 32'h0000_00FF, 6'd8,  1'b1, 3'd0, 32'h0000_0000},
    '{CMD_ENCODE, 8'h00, 32'h0000_0000, 6'd0,  1'b1, 3'd1, 32'hFF00_0000},
    // full-width code on the top table entry: four bytes
    '{CMD_LOAD,   8'hFF, 32'hFFFF_FFFF, 6'd32, 1'b1, 3'd0, 32'h0000_0000},
    '{CMD_ENCODE, 8'hFF, 32'h0000_0000, 6'd0,  1'b1, 3'd4, 32'hFFFF_FFFF},
    '{CMD_LOAD,   8'h01, 32'h0000_0005, 6'd3,  1'b1, 3'd0, 32'h0000_0000},
    '{CMD_ENCODE, 8'h01, 32'h0000_0000, 6'd0,  1'b1, 3'd0, 32'h0000_0000},
    // pad 101 with zeros
    '{CMD_FLUSH,  8'h00, 32'h0000_0000, 6'd0,  1'b1, 3'd1, 32'hA000_0000},
    '{CMD_FLUSH,  8'h00, 32'h0000_0000, 6'd0,  1'b1, 3'd0, 32'h0000_0000},
    // length 63 clips to 32
    '{CMD_LOAD,   8'h02, 32'hFFFF_FFFF, 6'd63, 1'b1, 3'd0, 32'h0000_0000},
    '{CMD_ENCODE, 8'h02, 32'h0000_0000, 6'd0,  1'b1, 3'd4, 32'hFFFF_FFFF},
    // zero-length code emits nothing
    '{CMD_LOAD,   8'h03, 32'h1234_5678, 6'd0,  1'b1, 3'd0, 32'h0000_0000},
    '{CMD_ENCODE, 8'h03, 32'h0000_0000, 6'd0,  1'b1, 3'd0, 32'h0000_0000},
    '{CMD_LOAD,   8'h04, 32'hAAAA_AAAA, 6'd1,  1'b1, 3'd0, 32'h0000_0000},
    '{CMD_ENCODE, 8'h04, 32'h0000_0000, 6'd0,  1'b1, 3'd0, 32'h0000_0000},
    // one pending zero plus seven zeros completes a byte
    '{CMD_LOAD,   8'h05, 32'h0000_0000, 6'd7,  1'b1, 3'd0, 32'h0000_0000},
    '{CMD_ENCODE, 8'h05, 32'h0000_0000, 6'd0,  1'b1, 3'd1, 32'h0000_0000},
    '{CMD_LOAD,   8'h06, 32'h7FFF_FFFF, 6'd31, 1'b1, 3'd0, 32'h0000_0000},
    // 3 + 31 bits: four bytes with two left over
    '{CMD_ENCODE, 8'h01, 32'h0000_0000, 6'd0,  1'b0, 3'd0, 32'h0000_0000},
    '{CMD_ENCODE, 8'h06, 32'h0000_0000, 6'd0,  1'b0, 3'd0, 32'h0000_0000},
    '{CMD_LOAD,   8'hAA, 32'h8000_0001, 6'd33, 1'b1, 3'd0, 32'h0000_0000},
    '{CMD_ENCODE, 8'hAA, 32'h0000_0000, 6'd0,  1'b0, 3'd0, 32'h0000_0000},
    '{CMD_FLUSH,  8'h55, 32'h0000_0000, 6'd0,  1'b0, 3'd0, 32'h0000_0000}
  };

  // ---------------------------------------------------------------------
  // Receiver: random stall, or a counted hold-off when one is requested.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : rx_stall_gen
    int hold_left;
    int hold_served;
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (hold_served != hold_reqs) begin
      hold_served++;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
    end
  end

  // Output check: each byte transfer against the oldest byte owed.
  always @(posedge clk) begin : check_output
    byte_due_t due;
    if (!rst && out_valid && !out_stall) begin
      if (bytes_due.size() == 0) begin
        flag_mismatch($sformatf("byte %02h (last %0b) with nothing owed", out_byte, last));
      end else begin
        due = bytes_due.pop_front();
        if (out_byte !== due.b)
          flag_mismatch($sformatf("out_byte %02h, expected %02h", out_byte, due.b));
        if (last !== due.last)
          flag_mismatch($sformatf("last %0b on byte %02h, expected %0b",
                                  last, out_byte, due.last));
        bytes_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d bytes still owed", cycles, bytes_due.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_DIRECTED; i++)
      send_item(directed_rows[i].op, directed_rows[i].sym, directed_rows[i].word,
                directed_rows[i].len, directed_rows[i].typed,
                int'(directed_rows[i].n_bytes), directed_rows[i].bytes);
    wait_all_bytes();

    // sender mostly busy, receiver mostly stalling
    tx_idle_pct = 31;
    rx_stall_pct <= 61;
    repeat (150) send_random_item();
    wait_all_bytes();

    // the other way round
    tx_idle_pct = 61;
    rx_stall_pct <= 31;
    repeat (150) send_random_item();
    wait_all_bytes();

    // no idling at all
    tx_idle_pct = 0;
    rx_stall_pct <= 0;
    repeat (80) send_random_item();

    // receiver holds off while full-width codes keep coming: input backs up
    hold_reqs <= hold_reqs + 1;
    send_item(CMD_LOAD, 8'hC3, $urandom(), 6'd32, 1'b0, 0, '0);
    repeat (30) send_item(CMD_ENCODE, 8'hC3, $urandom(), 6'd0, 1'b0, 0, '0);

    repeat (90) send_random_item();
    wait_all_bytes();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d input transfers (%0d directed), checked %0d bytes, %0d symbols loaded.",
             items_sent, N_DIRECTED, bytes_checked, loaded_syms.size());
    $display("Idle mixes 31/61, 61/31 and none, plus a %0d-cycle output hold-off.",
             HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
